FILE: rtl/ptt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptt_pkg
// Types and codes shared by the periodic timer table and its slot evaluator.
// ----------------------------------------------------------------------------
package ptt_pkg;

	// Command opcodes.
	localparam logic [1:0] OP_SET   = 2'd0;
	localparam logic [1:0] OP_CLEAR = 2'd1;
	localparam logic [1:0] OP_CHECK = 2'd2;
	localparam logic [1:0] OP_WAKE  = 2'd3;

	// Result kinds.
	localparam logic [1:0] KIND_ACK   = 2'd0;
	localparam logic [1:0] KIND_FIRED = 2'd1;
	localparam logic [1:0] KIND_NONE  = 2'd2;
	localparam logic [1:0] KIND_CHECK = 2'd3;

	// At most this many fires are reported for one wake.
	localparam int MAX_FIRES  = 16;
	localparam int FIRE_CNT_W = 5;

	// Largest remaining time that a set may store.
	localparam logic [32:0] REMAIN_MAX = 33'h0_FFFF_FFFF;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [3:0]  slot;
		logic [30:0] period;
		logic        repeat_on_fire;
		logic [31:0] now;
	} cmd_item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [3:0] slot_res;
		logic       due;
		logic       last;
	} res_item_t;

	// One entry of the slot memory; remaining is a two's complement value.
	typedef struct packed {
		logic        repeat_on_fire;
		logic [30:0] period;
		logic [32:0] remaining;
	} slot_word_t;

	// Outcome of evaluating one slot during a sweep.
	typedef struct packed {
		logic       fire;
		logic       due;
		logic       armed_next;
		slot_word_t word;
	} eval_res_t;

endpackage
`default_nettype wire

FILE: rtl/periodic_timer_table.sv
// A set or clear gives its acknowledge from the execute state; a check or wake gives
// its final result from the finish state, after the sweep over all TIMER_SLOTS slots.
// A new item is accepted only in the idle state, once the previous one is done; the
// sweep reads the slots one after another over the single read port of the slot RAM.
// A stalled fire report holds the sweep while the consumer holds back. Reset clears the
// armed flags, the listed flag and the last wake time at once; no clearing pass.
`default_nettype none
// ----------------------------------------------------------------------------
// periodic_timer_table
// Table of millisecond timer slots with periodic reload. Slot data sits in
// one RAM; check and wake sweep it with a read-evaluate-write pipeline.
// ----------------------------------------------------------------------------
module periodic_timer_table #(
	parameter int TIMER_SLOTS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cmd_valid,
	output logic                    cmd_ready,
	input  wire ptt_pkg::cmd_item_t cmd,
	output logic                    res_valid,
	input  wire logic               res_ready,
	output ptt_pkg::res_item_t      res
);
	import ptt_pkg::*;

	localparam int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
	localparam int CNT_W = $clog2(TIMER_SLOTS + 1);
	localparam int WORD_W = $bits(slot_word_t);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SWEEP,
		ST_FINISH
	} state_t;

	// Control state.
	state_t                  state_q;
	logic [TIMER_SLOTS-1:0]  armed_q;
	logic                    any_listed_q;
	logic [31:0]             lwt_q;
	logic [CNT_W-1:0]        rd_cnt_q;
	logic                    v_s1;
	logic                    pend_v_q;
	logic [FIRE_CNT_W-1:0]   fires_q;
	logic                    due_acc_q;
	logic                    any_acc_q;
	logic                    res_valid_q;

	// Payload registers.
	cmd_item_t               cmd_q;
	logic [31:0]             elapsed_q;
	logic [IDX_W-1:0]        idx_s1;
	logic [3:0]              pend_slot_q;
	res_item_t               res_q;

	// Datapath.
	logic                    can_push;
	logic                    push;
	res_item_t               push_item;
	logic                    slot_ok;
	logic [IDX_W-1:0]        slot_idx;
	logic                    is_wake;
	logic                    slot_armed;
	logic                    report;
	logic                    stall;
	logic                    adv;
	logic                    more;
	logic                    ram_we;
	logic [IDX_W-1:0]        ram_waddr;
	slot_word_t              ram_wword;
	logic                    ram_re;
	logic [WORD_W-1:0]       ram_rdata;
	slot_word_t              rd_word;
	slot_word_t              set_word;
	logic [32:0]             set_sum;
	eval_res_t               ev;

	assign cmd_ready = (state_q == ST_IDLE);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// The output register frees itself when the current result is taken.
	assign can_push = !res_valid_q || res_ready;

	// Slot numbers beyond the table are acknowledged but change nothing.
	assign slot_ok  = ({28'd0, cmd_q.slot} < 32'(TIMER_SLOTS));
	assign slot_idx = IDX_W'({28'd0, cmd_q.slot});
	assign is_wake  = (cmd_q.opcode == OP_WAKE);

	// Remaining time of a newly set slot is its period plus the time since the
	// last wake, held at the 32-bit ceiling.
	assign set_sum = {2'b00, cmd_q.period} + {1'b0, elapsed_q};
	always_comb begin
		set_word.repeat_on_fire = cmd_q.repeat_on_fire;
		set_word.period         = cmd_q.period;
		set_word.remaining      = set_sum[32] ? REMAIN_MAX : set_sum;
	end

	// Evaluation stage of the sweep: the RAM output belongs to slot idx_s1.
	assign rd_word    = slot_word_t'(ram_rdata);
	assign slot_armed = v_s1 && armed_q[idx_s1];

	ptt_slot_eval u_eval (
		.armed   (slot_armed),
		.word    (rd_word),
		.elapsed (elapsed_q),
		.res     (ev)
	);

	// A reportable fire is held back by one so that the final one can carry
	// last. Pushing the held one out is the only thing that can stall the sweep.
	assign report = is_wake && ev.fire && (fires_q < FIRE_CNT_W'(MAX_FIRES));
	assign stall  = v_s1 && report && pend_v_q && !can_push;
	assign adv    = (state_q == ST_SWEEP) && !stall;
	assign more   = (rd_cnt_q < CNT_W'(TIMER_SLOTS));

	// Read port: the sweep only reads ahead when the evaluation stage moves,
	// so a stalled slot keeps its data on the RAM output.
	assign ram_re = adv && more;

	// Write port: a set in the execute state, or a write-back during a wake.
	// Different slots are read and written in the same cycle, never the same one.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = slot_idx;
		ram_wword = set_word;
		if (state_q == ST_EXEC) begin
			ram_we = (cmd_q.opcode == OP_SET) && slot_ok && can_push;
		end else if (adv && slot_armed && is_wake) begin
			ram_we    = 1'b1;
			ram_waddr = idx_s1;
			ram_wword = ev.word;
		end
	end

	ptt_ram #(
		.WIDTH (WORD_W),
		.DEPTH (TIMER_SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wword),
		.re    (ram_re),
		.raddr (rd_cnt_q[IDX_W-1:0]),
		.rdata (ram_rdata)
	);

	// Result selection.
	always_comb begin
		push      = 1'b0;
		push_item = '0;
		case (state_q)
			ST_EXEC: begin
				push           = can_push;
				push_item.kind = KIND_ACK;
				push_item.last = 1'b1;
			end
			ST_SWEEP: begin
				if (v_s1 && report && pend_v_q && can_push) begin
					push               = 1'b1;
					push_item.kind     = KIND_FIRED;
					push_item.slot_res = pend_slot_q;
				end
			end
			ST_FINISH: begin
				push           = can_push;
				push_item.last = 1'b1;
				if (!is_wake) begin
					push_item.kind = KIND_CHECK;
					push_item.due  = due_acc_q;
				end else if (pend_v_q) begin
					push_item.kind     = KIND_FIRED;
					push_item.slot_res = pend_slot_q;
				end else begin
					push_item.kind = KIND_NONE;
				end
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	// Sequencer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			armed_q      <= '0;
			any_listed_q <= 1'b0;
			lwt_q        <= '0;
			rd_cnt_q     <= '0;
			v_s1         <= 1'b0;
			pend_v_q     <= 1'b0;
			fires_q      <= '0;
			due_acc_q    <= 1'b0;
			any_acc_q    <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			if (push) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						rd_cnt_q  <= '0;
						v_s1      <= 1'b0;
						fires_q   <= '0;
						due_acc_q <= 1'b0;
						any_acc_q <= 1'b0;
						if (cmd.opcode == OP_SET || cmd.opcode == OP_CLEAR) begin
							state_q <= ST_EXEC;
						end else begin
							state_q <= ST_SWEEP;
						end
					end
				end
				ST_EXEC: begin
					if (can_push) begin
						if (cmd_q.opcode == OP_SET && slot_ok) begin
							armed_q[slot_idx] <= 1'b1;
							any_listed_q      <= 1'b1;
							// An empty table restarts its time base at this set.
							if (!any_listed_q) begin
								lwt_q <= cmd_q.now;
							end
						end else if (cmd_q.opcode == OP_CLEAR && slot_ok) begin
							armed_q[slot_idx] <= 1'b0;
						end
						state_q <= ST_IDLE;
					end
				end
				ST_SWEEP: begin
					if (adv) begin
						if (more) begin
							v_s1     <= 1'b1;
							rd_cnt_q <= rd_cnt_q + CNT_W'(1);
						end else begin
							v_s1 <= 1'b0;
						end
						if (v_s1) begin
							due_acc_q <= due_acc_q || ev.due;
							if (is_wake) begin
								armed_q[idx_s1] <= ev.armed_next;
								any_acc_q       <= any_acc_q || ev.armed_next;
								if (report) begin
									pend_v_q <= 1'b1;
									fires_q  <= fires_q + FIRE_CNT_W'(1);
								end
							end
						end else if (!more) begin
							state_q <= ST_FINISH;
						end
					end
				end
				ST_FINISH: begin
					if (can_push) begin
						if (is_wake) begin
							lwt_q <= cmd_q.now;
							// Slots still armed after the wake are exactly those
							// that stay listed.
							any_listed_q <= any_acc_q;
						end
						pend_v_q <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers, no reset needed.
	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			cmd_q <= cmd;
			if (cmd.opcode == OP_SET && !any_listed_q) begin
				elapsed_q <= '0;
			end else begin
				elapsed_q <= cmd.now - lwt_q;
			end
		end
		if (adv && more) begin
			idx_s1 <= rd_cnt_q[IDX_W-1:0];
		end
		if (adv && v_s1 && report) begin
			pend_slot_q <= 4'(idx_s1);
		end
		if (push) begin
			res_q <= push_item;
		end
	end

`ifndef SYNTH
	// An armed slot is always a listed one, so the table cannot look empty.
	a_armed_listed: assert property (@(posedge clk) disable iff (!arst_n)
		(armed_q != '0) |-> any_listed_q)
		else $error("armed slot while table is marked empty");

	// The fire counter never passes the reporting limit.
	a_fire_cap: assert property (@(posedge clk) disable iff (!arst_n)
		fires_q <= FIRE_CNT_W'(MAX_FIRES))
		else $error("fire count beyond reporting limit");

	// A new item only starts with the sweep pipeline and the held fire empty.
	a_clean_start: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && cmd_ready) |-> (!v_s1 && !pend_v_q))
		else $error("item accepted with sweep state left over");

	// After a stalled sweep cycle the evaluation stage still holds its slot.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		stall |=> (v_s1 && $stable(idx_s1) && $stable(rd_cnt_q)))
		else $error("sweep moved while stalled");
`endif

endmodule
`default_nettype wire

FILE: rtl/ptt_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptt_ram
// Simple dual-port RAM with one write port and a registered read port.
// ----------------------------------------------------------------------------
module ptt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                     clk,
	input  wire logic                                     we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                         wdata,
	input  wire logic                                     re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

FILE: rtl/ptt_slot_eval.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptt_slot_eval
// Evaluates one slot read from memory: due test, elapsed-time subtraction,
// expiry and reload.
// ----------------------------------------------------------------------------
module ptt_slot_eval (
	input  wire logic               armed,
	input  wire ptt_pkg::slot_word_t word,
	input  wire logic [31:0]        elapsed,
	output ptt_pkg::eval_res_t      res
);
	import ptt_pkg::*;

	logic [33:0] rem_ext;
	logic [33:0] el_ext;
	logic [33:0] diff;
	logic        expired;

	assign rem_ext = {word.remaining[32], word.remaining};
	assign el_ext  = {2'b00, elapsed};
	assign diff    = rem_ext - el_ext;
	// The slot expires when what is left after the subtraction is zero or less.
	assign expired = diff[33] || (diff == 34'd0);

	always_comb begin
		res            = '0;
		res.due        = armed && ($signed(rem_ext) <= $signed(el_ext));
		res.fire       = armed && expired;
		res.armed_next = armed && !(expired && !word.repeat_on_fire);
		res.word       = word;
		if (expired && word.repeat_on_fire) begin
			res.word.remaining = {2'b00, word.period};
		end else begin
			res.word.remaining = diff[32:0];
		end
	end

endmodule
`default_nettype wire
